@@ src/lrc_pkg.sv @@
// ----------------------------------------------------------------------------
// lrc_pkg
// shared types and constants of the lab to rgb pixel converter
// ----------------------------------------------------------------------------
package lrc_pkg;

  // pipeline depth, front to output register
  localparam int FRONT_STAGES = 2;
  localparam int INV_STAGES   = 3;
  localparam int MAT_STAGES   = 2;
  localparam int CHAN_STAGES  = 6;
  localparam int SQRT_STAGES  = 4;
  localparam int NUM_STAGES   = FRONT_STAGES + INV_STAGES + MAT_STAGES + CHAN_STAGES
                                + SQRT_STAGES;

  // lab coordinates and inverse function values in q20
  typedef logic signed [21:0] labq_t;
  typedef logic signed [23:0] fval_t;
  // matrix row sums, q20 scaled by 1e6
  typedef logic signed [45:0] acc_t;
  typedef logic signed [22:0] coef_t;

  typedef struct packed {
    logic zero;
    logic sat;
  } clamp_t;

  // xyz to rgb matrix, units of 1e-6
  localparam coef_t COEF [3][3] = '{
    '{ 23'sd3240449, -23'sd1537136, -23'sd498531},
    '{-23'sd969265,   23'sd1876011,  23'sd41556},
    '{ 23'sd55643,   -23'sd204026,   23'sd1057229}
  };

  // row sum at and above which the scaled channel reaches 1.0
  localparam acc_t SAT_ACC [3] = '{
    46'sd1263305500000, 46'sd994363500000, 46'sd952991500000
  };

  // scale * 64 = 15625 * A + B, so v = A * t + floor(B * t / 15625)
  localparam logic [12:0] SCL_A [3] = '{13'd3399, 13'd4319, 13'd4506};
  localparam logic [13:0] SCL_B [3] = '{14'd12289, 14'd4905, 14'd12950};

endpackage

@@ src/lrc_front.sv @@
// ----------------------------------------------------------------------------
// lrc_front
// forms m, l and n in q20 from the fixed-point lab input
// ----------------------------------------------------------------------------
module lrc_front import lrc_pkg::*; (
  input  logic               clk_i,
  input  logic [1:0]         en_i,
  input  logic [14:0]        l_star_i,
  input  logic signed [15:0] a_star_i,
  input  logic signed [15:0] b_star_i,
  output labq_t              m_o,
  output labq_t              l_o,
  output labq_t              n_o
);

  // stage 1: reciprocal estimates of the three small quotients
  logic [14:0]        u_d, u_q;
  logic [14:0]        lc;
  logic [18:0]        ym_d, ym_q;
  logic [38:0]        pm;
  logic [13:0]        qm0_d, qm0_q;
  logic signed [22:0] ya_s;
  logic [20:0]        ya_d, ya_q;
  logic [42:0]        pa;
  logic [13:0]        qa0_d, qa0_q;
  logic signed [21:0] yb_s;
  logic [19:0]        yb_d, yb_q;
  logic [41:0]        pb;
  logic [14:0]        qb0_d, qb0_q;
  logic signed [15:0] a_q, b_q;

  always_comb begin
    lc    = (l_star_i > 15'd25600) ? 15'd25600 : l_star_i;
    u_d   = lc + 15'd4096;
    ym_d  = 19'(u_d) * 19'd9 + 19'd14;
    pm    = 39'(ym_d) * 39'd578525;
    qm0_d = pm[37:24];
    // offset keeps the dividend positive
    ya_s  = 23'(a_star_i) * 23'sd24 + 23'sd786437;
    ya_d  = ya_s[20:0];
    pa    = 43'(ya_d) * 43'd2147484;
    qa0_d = pa[41:28];
    yb_s  = 22'(b_star_i) * 22'sd12 + 22'sd393237;
    yb_d  = yb_s[19:0];
    pb    = 42'(yb_d) * 42'd2684355;
    qb0_d = pb[40:26];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      u_q   <= u_d;
      ym_q  <= ym_d;
      qm0_q <= qm0_d;
      ya_q  <= ya_d;
      qa0_q <= qa0_d;
      yb_q  <= yb_d;
      qb0_q <= qb0_d;
      a_q   <= a_star_i;
      b_q   <= b_star_i;
    end
  end

  // stage 2: quotient correction and sums
  logic signed [20:0] rm;
  logic [13:0]        qm;
  logic [20:0]        m;
  logic signed [21:0] ra;
  logic [13:0]        qa;
  logic signed [20:0] rb;
  logic [14:0]        qb;
  logic signed [22:0] l_s;
  logic signed [23:0] n_s;
  labq_t              m_d, l_d, n_d;

  always_comb begin
    rm  = $signed(21'(ym_q)) - $signed(21'(qm0_q) * 21'd29);
    qm  = qm0_q - 14'(rm[20]);
    m   = 21'(u_q) * 21'd35 + 21'(qm);
    ra  = $signed(22'(ya_q)) - $signed(22'(qa0_q) * 22'd125);
    qa  = qa0_q - 14'(ra[21]);
    rb  = $signed(21'(yb_q)) - $signed(21'(qb0_q) * 21'd25);
    qb  = qb0_q - 15'(rb[20]);
    l_s = $signed(23'(m)) + (23'(a_q) <<< 3) + $signed(23'(qa)) - 23'sd6291;
    n_s = $signed(24'(m)) - 24'(b_q) * 24'sd20 - $signed(24'(qb)) + 24'sd15729;
    m_d = $signed(22'(m));
    l_d = l_s[21:0];
    n_d = n_s[21:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      m_o <= m_d;
      l_o <= l_d;
      n_o <= n_d;
    end
  end

endmodule

@@ src/lrc_lab_inv.sv @@
// ----------------------------------------------------------------------------
// lrc_lab_inv
// lab inverse function of one coordinate: cube or linear segment
// ----------------------------------------------------------------------------
module lrc_lab_inv import lrc_pkg::*; (
  input  logic       clk_i,
  input  logic [2:0] en_i,
  input  labq_t      t_i,
  output fval_t      f_o
);

  // stage 1: square, linear dividend
  logic               big_d, big_q3, big_q4;
  logic [20:0]        tu_d, tu_q3;
  logic [41:0]        sqp_d, sqp_q3;
  logic signed [35:0] ys;
  logic [31:0]        y_d, y_q3, y_q4;

  always_comb begin
    big_d = (t_i >= 22'sd216947);
    tu_d  = t_i[20:0];
    sqp_d = 42'(tu_d) * 42'(tu_d);
    // 108 * (29 t - 4) plus rounding, offset positive
    ys    = 36'(t_i) * 36'sd3132 + 36'sd1648822604;
    y_d   = ys[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      big_q3 <= big_d;
      tu_q3  <= tu_d;
      sqp_q3 <= sqp_d;
      y_q3   <= y_d;
    end
  end

  // stage 2: cube product, reciprocal of 24389
  logic [42:0] sqr;
  logic [21:0] sq;
  logic [42:0] cp_d, cp_q4;
  logic [49:0] lp;
  logic [16:0] qf0_d, qf0_q4;

  always_comb begin
    sqr   = 43'(sqp_q3) + 43'd524288;
    sq    = sqr[41:20];
    cp_d  = 43'(sq) * 43'(tu_q3);
    lp    = 50'(y_q3) * 50'd176103;
    qf0_d = lp[48:32];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      big_q4 <= big_q3;
      cp_q4  <= cp_d;
      y_q4   <= y_q3;
      qf0_q4 <= qf0_d;
    end
  end

  // stage 3: rounding, quotient correction, select
  logic [43:0]        cr;
  logic [22:0]        fc;
  logic signed [33:0] rl;
  logic [16:0]        qf;
  fval_t              fl, f_d;

  always_comb begin
    cr  = 44'(cp_q4) + 44'd524288;
    fc  = cr[42:20];
    rl  = $signed(34'(y_q4)) - $signed(34'(qf0_q4) * 34'd24389);
    qf  = qf0_q4 - 17'(rl[33]);
    fl  = $signed(24'(qf)) - 24'sd86178;
    f_d = big_q4 ? $signed(24'(fc)) : fl;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      f_o <= f_d;
    end
  end

endmodule

@@ src/lrc_matrix.sv @@
// ----------------------------------------------------------------------------
// lrc_matrix
// xyz to rgb 3x3 matrix: products, then row sums
// ----------------------------------------------------------------------------
module lrc_matrix import lrc_pkg::*; (
  input  logic       clk_i,
  input  logic [1:0] en_i,
  input  fval_t      f_i [3],
  output acc_t       acc_o [3]
);

  acc_t prod_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int c = 0; c < 3; c++) begin
        for (int i = 0; i < 3; i++) begin
          prod_q[c][i] <= 46'(COEF[c][i]) * 46'(f_i[i]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int c = 0; c < 3; c++) begin
        acc_o[c] <= prod_q[c][0] + prod_q[c][1] + prod_q[c][2];
      end
    end
  end

endmodule

@@ src/lrc_chan.sv @@
// ----------------------------------------------------------------------------
// lrc_chan
// rounding by 1e6, clamp to 0..1 and scaling of the three channels to q32
// ----------------------------------------------------------------------------
module lrc_chan import lrc_pkg::*; (
  input  logic        clk_i,
  input  logic [5:0]  en_i,
  input  acc_t        acc_i [3],
  output logic [31:0] v_o [3],
  output clamp_t      clamp_o [3]
);

  clamp_t      cl_q [5][3];
  logic [34:0] y_q8 [3];
  logic [34:0] y_q9 [3];
  logic [20:0] qt0_q [3];
  logic [20:0] t_q [3];
  logic [31:0] at_q11 [3];
  logic [31:0] at_q12 [3];
  logic [33:0] bt_q11 [3];
  logic [33:0] bt_q12 [3];
  logic [20:0] qv0_q [3];

  clamp_t             cl_d [3];
  logic [45:0]        x [3];
  logic [56:0]        pt [3];
  logic signed [36:0] rt [3];
  logic [20:0]        t_d [3];
  logic [32:0]        at [3];
  logic [34:0]        bt [3];
  logic [54:0]        pv [3];
  logic signed [35:0] rv [3];
  logic [20:0]        qv [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cl_d[c].zero = (acc_i[c] < 46'sd500000);
      cl_d[c].sat  = (acc_i[c] >= SAT_ACC[c]);
      x[c]         = acc_i[c] + 46'sd500000;
      pt[c]        = 57'(y_q8[c]) * 57'd2199024;
      rt[c]        = $signed(37'(y_q9[c])) - $signed(37'(qt0_q[c]) * 37'd15625);
      t_d[c]       = qt0_q[c] - 21'(rt[c][36]);
      at[c]        = 33'(t_q[c]) * 33'(SCL_A[c]);
      bt[c]        = 35'(t_q[c]) * 35'(SCL_B[c]);
      pv[c]        = 55'(bt_q11[c]) * 55'd1099512;
      rv[c]        = $signed(36'(bt_q12[c])) - $signed(36'(qv0_q[c]) * 36'd15625);
      qv[c]        = qv0_q[c] - 21'(rv[c][35]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      if (en_i[0]) begin
        cl_q[0][c] <= cl_d[c];
        y_q8[c]    <= x[c][40:6];
      end
      if (en_i[1]) begin
        cl_q[1][c] <= cl_q[0][c];
        y_q9[c]    <= y_q8[c];
        qt0_q[c]   <= pt[c][55:35];
      end
      if (en_i[2]) begin
        cl_q[2][c] <= cl_q[1][c];
        t_q[c]     <= t_d[c];
      end
      if (en_i[3]) begin
        cl_q[3][c] <= cl_q[2][c];
        at_q11[c]  <= at[c][31:0];
        bt_q11[c]  <= bt[c][33:0];
      end
      if (en_i[4]) begin
        cl_q[4][c] <= cl_q[3][c];
        at_q12[c]  <= at_q11[c];
        bt_q12[c]  <= bt_q11[c];
        qv0_q[c]   <= pv[c][54:34];
      end
      if (en_i[5]) begin
        clamp_o[c] <= cl_q[4][c];
        v_o[c]     <= at_q12[c] + 32'(qv[c]);
      end
    end
  end

endmodule

@@ src/lrc_isqrt.sv @@
// ----------------------------------------------------------------------------
// lrc_isqrt
// pipelined integer square root of a q32 value, four result bits per stage
// ----------------------------------------------------------------------------
module lrc_isqrt import lrc_pkg::*; (
  input  logic        clk_i,
  input  logic [3:0]  en_i,
  input  logic [31:0] v_i,
  input  clamp_t      clamp_i,
  output logic [15:0] root_o
);

  typedef struct packed {
    logic [16:0] rem;
    logic [15:0] root;
    logic [31:0] bits;
    clamp_t      cl;
  } sq_t;

  function automatic sq_t sq_step4(sq_t st);
    sq_t         r;
    logic [18:0] w;
    logic [18:0] tr;
    r = st;
    for (int k = 0; k < 4; k++) begin
      w      = {r.rem, r.bits[31:30]};
      r.bits = {r.bits[29:0], 2'b00};
      tr     = {1'b0, r.root, 2'b01};
      if (w >= tr) begin
        r.rem  = 17'(w - tr);
        r.root = {r.root[14:0], 1'b1};
      end else begin
        r.rem  = w[16:0];
        r.root = {r.root[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  sq_t st_q [4];
  sq_t st_in;

  always_comb begin
    st_in.rem  = '0;
    st_in.root = '0;
    st_in.bits = v_i;
    st_in.cl   = clamp_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) st_q[0] <= sq_step4(st_in);
    if (en_i[1]) st_q[1] <= sq_step4(st_q[0]);
    if (en_i[2]) st_q[2] <= sq_step4(st_q[1]);
    if (en_i[3]) st_q[3] <= sq_step4(st_q[2]);
  end

  // clamped channels bypass the root
  always_comb begin
    if (st_q[3].cl.zero) begin
      root_o = 16'h0000;
    end else if (st_q[3].cl.sat) begin
      root_o = 16'hFFFF;
    end else begin
      root_o = st_q[3].root;
    end
  end

endmodule

@@ src/lab_to_rgb_pixel_converter.sv @@
// ----------------------------------------------------------------------------
// lab_to_rgb_pixel_converter
// cie l*a*b* to rgb pixel converter with square-root gamma, fully pipelined
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   l_star, a_star, b_star
//  m_axis    out  m_axis_tvalid/m_axis_tready   red, green, blue
//
//  one item per clock while m_axis_tready does not stall the output
//  stages: 2 front, 3 lab inverse, 2 matrix, 6 channel scaling, 4 square root
//  every stage has a valid bit; a stage loads when it is empty or the next
//  one moves, so bubbles are squeezed out and input is taken while a result
//  waits in the output register
//  reset clears the valid bits only
// ----------------------------------------------------------------------------
module lab_to_rgb_pixel_converter import lrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // l_star [14:0], a_star [30:15], b_star [46:31], zero [47]
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // red [15:0], green [31:16], blue [47:32]
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);

  localparam int INV_LO  = FRONT_STAGES;
  localparam int MAT_LO  = INV_LO + INV_STAGES;
  localparam int CHAN_LO = MAT_LO + MAT_STAGES;
  localparam int SQRT_LO = CHAN_LO + CHAN_STAGES;

  // valid bits and ready chain
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES:0]   rdy;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    rdy[NUM_STAGES] = m_axis_tready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      rdy[i] = ~vld_q[i] | rdy[i+1];
    end
    en = rdy[NUM_STAGES-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) vld_q[i] <= vld_q[i-1];
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NUM_STAGES-1];

  // input fields
  logic [14:0]        l_star;
  logic signed [15:0] a_star;
  logic signed [15:0] b_star;

  assign l_star = s_axis_tdata[14:0];
  assign a_star = $signed(s_axis_tdata[30:15]);
  assign b_star = $signed(s_axis_tdata[46:31]);

  // m, l, n in q20
  labq_t m_v, l_v, n_v;

  lrc_front u_front (
    .clk_i    (clk_i),
    .en_i     (en[FRONT_STAGES-1:0]),
    .l_star_i (l_star),
    .a_star_i (a_star),
    .b_star_i (b_star),
    .m_o      (m_v),
    .l_o      (l_v),
    .n_o      (n_v)
  );

  // x from l, y from m, z from n
  fval_t xyz [3];

  lrc_lab_inv u_inv_x (
    .clk_i (clk_i),
    .en_i  (en[MAT_LO-1:INV_LO]),
    .t_i   (l_v),
    .f_o   (xyz[0])
  );

  lrc_lab_inv u_inv_y (
    .clk_i (clk_i),
    .en_i  (en[MAT_LO-1:INV_LO]),
    .t_i   (m_v),
    .f_o   (xyz[1])
  );

  lrc_lab_inv u_inv_z (
    .clk_i (clk_i),
    .en_i  (en[MAT_LO-1:INV_LO]),
    .t_i   (n_v),
    .f_o   (xyz[2])
  );

  // linear rgb row sums
  acc_t acc [3];

  lrc_matrix u_matrix (
    .clk_i (clk_i),
    .en_i  (en[CHAN_LO-1:MAT_LO]),
    .f_i   (xyz),
    .acc_o (acc)
  );

  // clamped and scaled q32 values
  logic [31:0] v [3];
  clamp_t      clamp [3];

  lrc_chan u_chan (
    .clk_i   (clk_i),
    .en_i    (en[SQRT_LO-1:CHAN_LO]),
    .acc_i   (acc),
    .v_o     (v),
    .clamp_o (clamp)
  );

  // square root gamma, last stage is the output register
  logic [15:0] rgb [3];

  for (genvar c = 0; c < 3; c++) begin : g_sqrt
    lrc_isqrt u_isqrt (
      .clk_i   (clk_i),
      .en_i    (en[NUM_STAGES-1:SQRT_LO]),
      .v_i     (v[c]),
      .clamp_i (clamp[c]),
      .root_o  (rgb[c])
    );
  end

  assign m_axis_tdata = {rgb[2], rgb[1], rgb[0]};

endmodule

@@ bench/lab_to_rgb_pixel_converter_test.sv @@
// ----------------------------------------------------------------------------
// lab_to_rgb_pixel_converter_test
// drives lab pixels through the converter under random idling and a long
// output hold-off, predicts each rgb pixel in fixed point and checks it
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lab_to_rgb_pixel_converter_test import lrc_pkg::*; ();

  localparam int LATENCY    = NUM_STAGES;
  localparam int CYCLE_CAP  = 400000;
  localparam int HOLD_LEN   = 60;

  typedef struct packed {
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } rgb_t;

  logic        clk_i;
  logic        rst_ni;
  logic [47:0] s_axis_tdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;

  // pixels still to come out of the pipeline, oldest first
  rgb_t        pending_pixels[$];
  int          mismatch_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_cycles;

  lab_to_rgb_pixel_converter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // fixed point prediction
  // ---------------------------------------------------------------------------

  // round to nearest, halves toward plus infinity
  function automatic longint round_div(longint num, longint den);
    longint t;
    t = num + den / 2;
    if (t >= 0) return t / den;
    return -((-t + den - 1) / den);
  endfunction

  // inverse of the lab companding curve, q20 in and out
  function automatic longint lab_inverse(longint t);
    longint unsigned u, sq;
    if (t * 29 >= 6 * 64'sd1048576) begin
      u  = t;
      sq = (u * u + 524288) >> 20;
      return longint'((sq * u + 524288) >> 20);
    end
    return round_div(108 * (29 * t - 4 * 64'sd1048576), 24389);
  endfunction

  function automatic logic [15:0] int_sqrt(longint unsigned v);
    longint unsigned root, bit_val;
    root    = 0;
    bit_val = 64'd1 << 62;
    while (bit_val > v) bit_val >>= 2;
    while (bit_val != 0) begin
      if (v >= root + bit_val) begin
        v    -= root + bit_val;
        root  = (root >> 1) + bit_val;
      end else begin
        root >>= 1;
      end
      bit_val >>= 2;
    end
    return (root > 65535) ? 16'hffff : root[15:0];
  endfunction

  // one matrix row, scaled, clamped and square rooted
  function automatic logic [15:0] gamma_channel(longint k0, longint k1, longint k2,
                                                longint scale, longint x, longint y,
                                                longint z);
    longint t, p;
    longint unsigned v;
    t = round_div(k0 * x + k1 * y + k2 * z, 1000000);
    if (t <= 0) return 16'd0;
    p = t * scale;
    if (p >= 64'sd1000000 * 64'sd1048576) return 16'hffff;
    v = (longint'(p) * 4096) / 1000000;
    return int_sqrt(v);
  endfunction

  function automatic rgb_t predict_pixel(logic [14:0] l_star, logic signed [15:0] a_star,
                                         logic signed [15:0] b_star);
    longint lv, m, l, n, x, y, z;
    rgb_t   px;
    lv = longint'(l_star);
    if (lv > 25600) lv = 25600; // lightness above 100 saturates
    m = round_div((lv + 4096) * 1024, 29);
    l = m + round_div(longint'(a_star) * 1024, 125);
    n = m - round_div(longint'(b_star) * 512, 25);
    x = lab_inverse(l);
    y = lab_inverse(m);
    z = lab_inverse(n);
    px.red   = gamma_channel(3240449, -1537136, -498531, 830026, x, y, z);
    px.green = gamma_channel(-969265, 1876011, 41556, 1054520, x, y, z);
    px.blue  = gamma_channel(55643, -204026, 1057229, 1100300, x, y, z);
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting and output checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("mismatch %s at %0t", msg, $realtime);
    mismatch_count++;
  endtask

  // receiver: random stall plus an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // counts down the hold-off, one cycle per clock
  always @(posedge clk_i) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  always @(posedge clk_i) begin
    rgb_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected item %h", m_axis_tdata));
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red)
          report_mismatch($sformatf("red: got %0d want %0d", got.red, want.red));
        if (got.green !== want.green)
          report_mismatch($sformatf("green: got %0d want %0d", got.green, want.green));
        if (got.blue !== want.blue)
          report_mismatch($sformatf("blue: got %0d want %0d", got.blue, want.blue));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout with %0d pixels pending", pending_pixels.size());
      $display("lab_to_rgb_pixel_converter_test: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // offers one pixel, holding it until accepted; valid stays high into the
  // next item so it is never lowered and raised within one step
  task automatic send_pixel(logic [14:0] l_star, logic [15:0] a_star, logic [15:0] b_star);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {1'b0, b_star, a_star, l_star};
    s_axis_tvalid <= 1'b1;
    pending_pixels.push_back(predict_pixel(l_star, a_star, b_star));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic go_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [14:0] lv[6] = '{15'd0, 15'd1, 15'd12800, 15'd25600, 15'd25601, 15'h7fff};
    logic [15:0] ab[4] = '{16'h0000, 16'h8000, 16'h7fff, 16'hffff};
    foreach (lv[i]) send_pixel(lv[i], 16'h0000, 16'h0000);
    foreach (ab[i]) begin
      send_pixel(15'd12800, ab[i], 16'h0000);
      send_pixel(15'd12800, 16'h0000, ab[i]);
    end
    // near the curve knee, then extreme and patterned chroma
    send_pixel(15'd2048, 16'h0000, 16'h0000);
    send_pixel(15'd2100, 16'h0100, 16'hff00);
    send_pixel(15'd25600, 16'h7fff, 16'h8000);
    send_pixel(15'd25600, 16'h8000, 16'h7fff);
    send_pixel(15'd0, 16'h8000, 16'h8000);
    send_pixel(15'd0, 16'h7fff, 16'h7fff);
    send_pixel(15'h5555, 16'h5555, 16'haaaa);
    send_pixel(15'h2aaa, 16'haaaa, 16'h5555);
    go_quiet();
  endtask

  task automatic test_random(int count);
    logic [14:0] lv;
    logic [15:0] av, bv;
    repeat (count) begin
      // mostly legal lightness with moderate chroma, some full range
      if ($urandom_range(9) < 7) begin
        lv = 15'($urandom_range(25600));
        av = 16'($urandom_range(65535) >> $urandom_range(4));
        bv = 16'($urandom_range(65535) >> $urandom_range(4));
        if ($urandom_range(1)) av = -av;
        if ($urandom_range(1)) bv = -bv;
      end else begin
        lv = 15'($urandom);
        av = 16'($urandom);
        bv = 16'($urandom);
      end
      send_pixel(lv, av, bv);
    end
    go_quiet();
  endtask

  task automatic test_backpressure();
    hold_cycles = HOLD_LEN;
    test_random(60);
  endtask

  task automatic drain();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    hold_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(320);
    send_idle_pct = 49;
    test_random(320);
    send_idle_pct  = 0;
    recv_stall_pct = 49;
    test_random(320);
    send_idle_pct = 19;
    recv_stall_pct = 19;
    test_random(320);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_backpressure();
    drain();

    if (mismatch_count == 0) begin
      $display("lab_to_rgb_pixel_converter_test: PASS");
    end else begin
      $display("lab_to_rgb_pixel_converter_test: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/lrc_pkg.sv
src/lrc_front.sv
src/lrc_lab_inv.sv
src/lrc_matrix.sv
src/lrc_chan.sv
src/lrc_isqrt.sv
src/lab_to_rgb_pixel_converter.sv
bench/lab_to_rgb_pixel_converter_test.sv
